### rtl/qte_pkg.sv
package qte_pkg;

	localparam int M_W      = 34;   // Q30 matrix terms, signed
	localparam int CX_W     = 36;   // CORDIC vector datapath
	localparam int ANG_W    = 34;   // Q30 radians, signed
	localparam int RAD_W    = 61;   // radicand of the square root
	localparam int ROOT_W   = 31;   // floor root, one bit per stage
	localparam int UNIT_W   = 16;

	localparam logic [28:0] DEG_SCALE_Q16 = 29'd480631834;
	localparam int X_LIMIT  = 11520;
	localparam int YZ_LIMIT = 23040;
	localparam logic [14:0] GIMBAL_THR_RST = 15'd32440;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [0:10] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576
	};

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} in_word_t;

	typedef struct packed {
		logic signed [14:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic               gimbal_lock;
	} out_word_t;

	// terms that ride along with the square root
	typedef struct packed {
		logic signed [M_W-1:0] s;
		logic signed [M_W-1:0] by;
		logic signed [M_W-1:0] bx;
		logic signed [M_W-1:0] cy;
		logic signed [M_W-1:0] cx;
		logic                  gim;
		logic                  pos;
	} side_t;

	typedef struct packed {
		logic gim;
		logic pos;
	} flag_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		logic signed [ANG_W-1:0] r;
		r = '0;
		if (i < 11)
			r = ATAN_TAB[i];
		else if (i <= 30)
			r = ANG_W'(64'sd1 <<< (30 - i));
		return r;
	endfunction

endpackage

### rtl/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  rad,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output side_t             out_side
);

	// stage j resolves root bit ROOT_W-1-j
	logic [RAD_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] res_s  [0:ROOT_W];
	side_t             side_s [0:ROOT_W];
	logic [ROOT_W:0]   vld_s;

	assign rem_s[0]  = rad;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int K = ROOT_W - 1 - j;
		logic [63:0] trial;
		logic        fit;

		assign trial = (64'(res_s[j]) << (K + 1)) + (64'd1 << (2 * K));
		assign fit   = 64'(rem_s[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j+1] <= 1'b0;
			else
				vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			side_s[j+1] <= side_s[j];
			if (fit) begin
				rem_s[j+1] <= rem_s[j] - trial[RAD_W-1:0];
				res_s[j+1] <= res_s[j] | (ROOT_W'(1) << K);
			end else begin
				rem_s[j+1] <= rem_s[j];
				res_s[j+1] <= res_s[j];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = res_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

endmodule

### rtl/qte_cordic.sv
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = 16,
	parameter int LIM   = 23040
) (
	input  logic                     clk,
	input  logic signed [M_W-1:0]    y,
	input  logic signed [M_W-1:0]    x,
	output logic signed [UNIT_W-1:0] units
);

	// registered stages: pre-rotation, STEPS iterations, scale, round
	logic signed [CX_W-1:0]  x_s   [0:STEPS];
	logic signed [CX_W-1:0]  y_s   [0:STEPS];
	logic signed [ANG_W-1:0] ang_s [0:STEPS];
	logic [STEPS:0]          zero_s;

	always_ff @(posedge clk) begin
		zero_s[0] <= (x == '0) && (y == '0);
		if (x < 0) begin
			if (y >= 0) begin
				x_s[0]   <= CX_W'(y);
				y_s[0]   <= -CX_W'(x);
				ang_s[0] <= ATAN_TAB[0] <<< 1;
			end else begin
				x_s[0]   <= -CX_W'(y);
				y_s[0]   <= CX_W'(x);
				ang_s[0] <= -(ATAN_TAB[0] <<< 1);
			end
		end else begin
			x_s[0]   <= CX_W'(x);
			y_s[0]   <= CX_W'(y);
			ang_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ANG_W-1:0] A = atan_entry(i);
		logic signed [CX_W-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1]   <= x_s[i] + dx;
				y_s[i+1]   <= y_s[i] - dy;
				ang_s[i+1] <= ang_s[i] + A;
			end else begin
				x_s[i+1]   <= x_s[i] - dx;
				y_s[i+1]   <= y_s[i] + dy;
				ang_s[i+1] <= ang_s[i] - A;
			end
		end
	end

	logic [ANG_W-1:0] mag;
	logic [62:0]      prod_q;
	logic             neg_q;
	logic [62:0]      rnd;
	logic [16:0]      u;

	assign mag = ang_s[STEPS] < 0 ? ANG_W'(-ang_s[STEPS]) : ANG_W'(ang_s[STEPS]);

	always_ff @(posedge clk) begin
		prod_q <= zero_s[STEPS] ? '0 : 63'(mag) * 63'(DEG_SCALE_Q16);
		neg_q  <= !zero_s[STEPS] && (ang_s[STEPS] < 0);
	end

	assign rnd = (prod_q + (63'd1 << 45)) >> 46;
	assign u   = (rnd > 63'(LIM)) ? 17'(LIM) : rnd[16:0];

	always_ff @(posedge clk)
		units <= neg_q ? -UNIT_W'(u) : UNIT_W'(u);

endmodule

### rtl/quaternion_to_euler_angles_unit.sv
// Quaternion to Y-X-Z Euler angles.
//
// Input channel: quat (four signed Q1.15 components) is taken at a rising
// edge with start high and busy low. busy is held low: the pipeline takes a
// word in every cycle.
// Output channel: angles (1/128 degree, plus gimbal_lock) is valid for one
// cycle while done is high. The receiver cannot stall, so the pipeline never
// holds; every word moves one stage per clock.
// Config channel: cfg_data is the 15-bit gimbal threshold (Q0.15 of |m21|),
// written when cfg_valid and cfg_ready are high. cfg_ready is always high.
// Write it only while no word is in flight.
//
// The pipeline has four front stages (products, matrix
// terms and gimbal test, square of the cross term, radicand), 31 stages of
// the bit-per-stage square root, CORDIC_STEPS + 3 stages of the three
// parallel CORDIC atan2 units, one output register. Throughput one word per
// cycle. Reset clears the valid line and loads the threshold with 32440.
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    quat,
	output logic        done,
	output out_word_t   angles,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int CL = CORDIC_STEPS + 3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [14:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= GIMBAL_THR_RST;
		else if (cfg_valid)
			thr_q <= cfg_data;
	end

	// s1: products
	logic valid_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start;
	end
	always_ff @(posedge clk) begin
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
		xy_s1 <= quat.quat_x * quat.quat_y;
		wz_s1 <= quat.quat_w * quat.quat_z;
		xz_s1 <= quat.quat_x * quat.quat_z;
		wy_s1 <= quat.quat_w * quat.quat_y;
		yz_s1 <= quat.quat_y * quat.quat_z;
		wx_s1 <= quat.quat_w * quat.quat_x;
	end

	// s2: matrix terms, gimbal test
	function automatic logic signed [M_W-1:0] dbl(input logic signed [31:0] p);
		return M_W'(p) <<< 1;
	endfunction

	localparam logic signed [M_W-1:0] ONE_Q30 = M_W'(64'sd1 <<< 30);

	logic signed [M_W-1:0] m00, m01, m10, m11, m20, m21, m22, thr;
	assign m00 = ONE_Q30 - dbl(yy_s1) - dbl(zz_s1);
	assign m01 = dbl(xy_s1) + dbl(wz_s1);
	assign m10 = dbl(xy_s1) - dbl(wz_s1);
	assign m11 = ONE_Q30 - dbl(xx_s1) - dbl(zz_s1);
	assign m20 = dbl(xz_s1) + dbl(wy_s1);
	assign m21 = dbl(yz_s1) - dbl(wx_s1);
	assign m22 = ONE_Q30 - dbl(xx_s1) - dbl(yy_s1);
	assign thr = M_W'({thr_q, 15'd0});

	logic        valid_s2;
	side_t       side_s2;
	logic [29:0] sabs_s2;
	logic        gim, pos;
	assign pos = m21 >= thr;
	assign gim = pos || (m21 <= -thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end
	always_ff @(posedge clk) begin
		side_s2.s   <= -m21;
		side_s2.by  <= m20;
		side_s2.bx  <= m22;
		side_s2.cy  <= gim ? m10 : m01;
		side_s2.cx  <= gim ? m00 : m11;
		side_s2.gim <= gim;
		side_s2.pos <= pos;
		// only used off the gimbal branch, where |m21| < 2^30
		sabs_s2     <= m21 < 0 ? 30'(-m21) : 30'(m21);
	end

	// s3: square of the cross term
	logic        valid_s3;
	side_t       side_s3;
	logic [59:0] sq_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= valid_s2;
	end
	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		sq_s3   <= 60'(sabs_s2) * 60'(sabs_s2);
	end

	// s4: radicand 1 - s^2
	logic             valid_s4;
	side_t            side_s4;
	logic [RAD_W-1:0] rad_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else
			valid_s4 <= valid_s3;
	end
	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		rad_s4  <= (RAD_W'(1) << 60) - RAD_W'(sq_s3);
	end

	logic              sq_valid;
	logic [ROOT_W-1:0] root;
	side_t             sq_side;

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.rad       (rad_s4),
		.in_side   (side_s4),
		.out_valid (sq_valid),
		.root      (root),
		.out_side  (sq_side)
	);

	logic signed [UNIT_W-1:0] ua, ub, uc;

	qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(X_LIMIT)) u_cordic_x (
		.clk   (clk),
		.y     (sq_side.s),
		.x     (M_W'(root)),
		.units (ua)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(YZ_LIMIT)) u_cordic_y (
		.clk   (clk),
		.y     (sq_side.by),
		.x     (sq_side.bx),
		.units (ub)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(YZ_LIMIT)) u_cordic_z (
		.clk   (clk),
		.y     (sq_side.cy),
		.x     (sq_side.cx),
		.units (uc)
	);

	// flags and valid ride beside the CORDIC units
	flag_t       flag_s [0:CL];
	logic [CL:0] vld_s;
	assign flag_s[0] = '{gim: sq_side.gim, pos: sq_side.pos};
	assign vld_s[0]  = sq_valid;

	for (genvar i = 0; i < CL; i++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk)
			flag_s[i+1] <= flag_s[i];
	end

	// output register
	flag_t fl;
	assign fl = flag_s[CL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_s[CL];
	end
	always_ff @(posedge clk) begin
		if (fl.gim) begin
			angles.angle_x <= fl.pos ? 15'(X_LIMIT) : -15'(X_LIMIT);
			angles.angle_y <= '0;
		end else begin
			angles.angle_x <= ua[14:0];
			angles.angle_y <= ub;
		end
		angles.angle_z     <= uc;
		angles.gimbal_lock <= fl.gim;
	end

endmodule

### bench/qte_checker.sv
`timescale 1ns / 100ps

module qte_checker import qte_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  in_word_t    quat,
	input  logic        done,
	input  out_word_t   angles,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [14:0] cfg_data,
	output int          fail_cnt,
	output int          pending
);

	localparam longint ONE_Q30 = 64'sd1 <<< 30;
	localparam longint unsigned SCALE_Q16 = 64'd480631834;

	longint arc_tab [0:10] = '{
		843314857, 497837829, 263043836, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576
	};

	logic [14:0] thr_reg;
	out_word_t   angle_q[$];

	function automatic longint arc_step(int i);
		if (i < 11)
			return arc_tab[i];
		if (i <= 30)
			return 64'sd1 <<< (30 - i);
		return 0;
	endfunction

	// vectoring rotation, Q30 radians out
	function automatic longint vec_atan2(longint yv, longint xv);
		longint ang, t, dx, dy;
		ang = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv;
				yv = -t;
				ang = 2 * arc_tab[0];
			end else begin
				xv = -yv;
				yv = t;
				ang = -2 * arc_tab[0];
			end
		end
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				ang += arc_step(i);
			end else begin
				xv -= dx;
				yv += dy;
				ang -= arc_step(i);
			end
		end
		return ang;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint to_deg128(longint rad, longint lim);
		longint unsigned mag;
		longint u;
		mag = (rad < 0) ? longint'(-rad) : longint'(rad);
		u = longint'((mag * SCALE_Q16 + (64'd1 << 45)) >> 46);
		if (u > lim)
			u = lim;
		return (rad < 0) ? -u : u;
	endfunction

	function automatic out_word_t euler_of(in_word_t q, logic [14:0] thr_val);
		longint x, y, z, w, m00, m01, m10, m11, m20, m21, m22, thr, s, ax, ay, az;
		longint unsigned c;
		out_word_t r;
		x = q.quat_x;
		y = q.quat_y;
		z = q.quat_z;
		w = q.quat_w;
		m00 = ONE_Q30 - 2*y*y - 2*z*z;
		m01 = 2*x*y + 2*w*z;
		m10 = 2*x*y - 2*w*z;
		m11 = ONE_Q30 - 2*x*x - 2*z*z;
		m20 = 2*x*z + 2*w*y;
		m21 = 2*y*z - 2*w*x;
		m22 = ONE_Q30 - 2*x*x - 2*y*y;
		thr = longint'(thr_val) <<< 15;
		if (m21 >= thr || m21 <= -thr) begin
			ax = (m21 >= thr) ? X_LIMIT : -X_LIMIT;
			ay = 0;
			az = to_deg128(vec_atan2(m10, m00), YZ_LIMIT);
			r.gimbal_lock = 1'b1;
		end else begin
			s = -m21;
			c = root_floor((64'd1 << 60) - longint'(s * s));
			ax = to_deg128(vec_atan2(s, longint'(c)), X_LIMIT);
			ay = to_deg128(vec_atan2(m20, m22), YZ_LIMIT);
			az = to_deg128(vec_atan2(m01, m11), YZ_LIMIT);
			r.gimbal_lock = 1'b0;
		end
		r.angle_x = ax[14:0];
		r.angle_y = ay[15:0];
		r.angle_z = az[15:0];
		return r;
	endfunction

	assign pending = angle_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			thr_reg  <= GIMBAL_THR_RST;
			fail_cnt <= 0;
			angle_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				thr_reg <= cfg_data;
			if (start && !busy)
				angle_q.push_back(euler_of(quat, thr_reg));
			if (done) begin
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected word %h", $time, angles);
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = angle_q.pop_front();
					if (want.angle_x !== angles.angle_x ||
					    want.angle_y !== angles.angle_y ||
					    want.angle_z !== angles.angle_z ||
					    want.gimbal_lock !== angles.gimbal_lock) begin
						$display("%0t: mismatch exp x=%0d y=%0d z=%0d g=%0b got x=%0d y=%0d z=%0d g=%0b",
							$time, want.angle_x, want.angle_y, want.angle_z,
							want.gimbal_lock, angles.angle_x, angles.angle_y,
							angles.angle_z, angles.gimbal_lock);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb import qte_pkg::*;;

	localparam int LATENCY = 16 + 39;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    quat;
	logic        done;
	out_word_t   angles;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;
	int          fail_cnt;
	int          pending;
	int          send_idle;

	quaternion_to_euler_angles_unit #(.CORDIC_STEPS(16)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .quat(quat),
		.done(done), .angles(angles), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	qte_checker #(.STEPS(16)) u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .quat(quat),
		.done(done), .angles(angles), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_cnt(fail_cnt), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the pipeline hangs
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// one input word; random idle cycles ahead of it per send_idle percent
	task automatic send_word(in_word_t q);
		logic ok;
		while ($urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		quat  <= q;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic send_quat(int x, int y, int z, int w);
		in_word_t q;
		q.quat_x = x[15:0];
		q.quat_y = y[15:0];
		q.quat_z = z[15:0];
		q.quat_w = w[15:0];
		send_word(q);
	endtask

	// wait until the pipeline drained, then set a new gimbal threshold
	task automatic write_threshold(logic [14:0] v);
		logic ok;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly unit quaternions, some raw noise, some near the gimbal pole
	task automatic send_random();
		real a, b, c, d, n;
		int  kind;
		kind = $urandom_range(99);
		if (kind < 60) begin
			a = $urandom_range(65535) - 32767.5;
			b = $urandom_range(65535) - 32767.5;
			c = $urandom_range(65535) - 32767.5;
			d = $urandom_range(65535) - 32767.5;
			n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
			send_quat(int'(a / n * 32767.0), int'(b / n * 32767.0),
				int'(c / n * 32767.0), int'(d / n * 32767.0));
		end else if (kind < 85) begin
			send_quat($urandom, $urandom, $urandom, $urandom);
		end else begin
			// w and x of equal size put |m21| near one
			a = 23170 - $urandom_range(600);
			b = $urandom_range(1) ? a : -a;
			send_quat(int'(b), $urandom_range(1200) - 600,
				$urandom_range(1200) - 600, int'(a));
		end
	endtask

	task automatic run_phase(int idle_pct, int count);
		send_idle = idle_pct;
		repeat (count) send_random();
	endtask

	initial begin
		int waited;
		arst_n    = 1'b0;
		start     = 1'b0;
		quat      = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		send_idle = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset threshold, extremes, identity, gimbal poles
		send_idle = 15;
		send_quat(0, 0, 0, 0);
		send_quat(0, 0, 0, 32767);
		send_quat(0, 0, 0, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(23170, 0, 0, 23170);
		send_quat(-23170, 0, 0, 23170);
		send_quat(23170, 23170, 0, 0);
		send_quat(0, 23170, 23170, 0);
		send_quat(0, 32767, 0, 0);
		send_quat(0, 0, 32767, 0);
		send_quat(32767, 0, 0, 0);
		send_quat(0, 23170, 0, 23170);
		send_quat(0, 0, 23170, 23170);
		send_quat(-32768, 0, 0, 32767);
		send_quat(22900, 300, -300, 22900);

		write_threshold(15'd0);
		send_quat(0, 0, 0, 32767);
		send_quat(100, 0, 0, 32767);
		send_quat(-100, 0, 0, 32767);
		run_phase(15, 20);

		write_threshold(15'd32767);
		send_quat(23170, 0, 0, 23170);
		send_quat(-32768, 0, 0, 32767);
		run_phase(15, 300);

		write_threshold(15'd32440);
		run_phase(79, 300);

		write_threshold(15'($urandom_range(32767)));
		run_phase(0, 200);

		write_threshold(15'($urandom_range(32000, 32767)));
		run_phase(0, 200);

		start <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);

		if (fail_cnt == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/qte_pkg.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles_unit.sv
bench/qte_checker.sv
bench/tb.sv
